### sv/lease_expiry_indexed_min_heap_macros.svh
// Assertion macros shared by the checker.
`ifndef LEASE_EXPIRY_INDEXED_MIN_HEAP_MACROS_SVH
`define LEASE_EXPIRY_INDEXED_MIN_HEAP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LEIMH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("leimh check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define LEIMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("leimh check failed");
`endif

### sv/leimh_pkg.sv
`default_nettype none
package leimh_pkg;
  localparam int unsigned HandleW = 6;
  localparam int unsigned HandleCount = 64;
  localparam int unsigned KeyW = 64;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_REPOSITION = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_PLACE,
    ST_RD_SELF,
    ST_WAIT_SELF,
    ST_RD_PARENT,
    ST_WAIT_PARENT,
    ST_RD_KIDA,
    ST_WAIT_KIDA,
    ST_RD_KIDB,
    ST_WAIT_KIDB,
    ST_DECIDE,
    ST_SWAP_B,
    ST_RD_MIN,
    ST_WAIT_MIN,
    ST_RESULT
  } state_t;

  function automatic logic earlier(input logic [KeyW-1:0] ea, input logic [KeyW-1:0] ia,
                                   input logic [KeyW-1:0] eb, input logic [KeyW-1:0] ib);
    earlier = (ea != eb) ? (ea < eb) : (ia < ib);
  endfunction
endpackage
`default_nettype wire

### sv/leimh_store.sv
`default_nettype none
module leimh_store
  import leimh_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned PW = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               slot_we,
  input  wire logic [PW-2:0]      slot_waddr,
  input  wire logic [HandleW-1:0] slot_wdata,
  input  wire logic [PW-2:0]      slot_raddr,
  output logic      [HandleW-1:0] slot_rdata,
  input  wire logic               pos_we,
  input  wire logic               pos_wpresent,
  input  wire logic [HandleW-1:0] pos_waddr,
  input  wire logic [PW-2:0]      pos_wdata,
  input  wire logic [HandleW-1:0] pos_raddr,
  output logic                    pos_rpresent,
  output logic      [PW-2:0]      pos_rdata,
  input  wire logic               key_we,
  input  wire logic [HandleW-1:0] key_waddr,
  input  wire logic               key_wident,
  input  wire logic [KeyW-1:0]    key_wexp,
  input  wire logic [KeyW-1:0]    key_wid,
  input  wire logic [HandleW-1:0] key_raddr,
  output logic      [KeyW-1:0]    key_rexp,
  output logic      [KeyW-1:0]    key_rid
);
  logic [HandleW-1:0] slot_mem [DEPTH];
  logic [PW-2:0]      pos_mem [HandleCount];
  logic [KeyW-1:0]    exp_mem [HandleCount];
  logic [KeyW-1:0]    id_mem [HandleCount];
  logic [HandleCount-1:0] present_r;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata <= pos_mem[pos_raddr];
    if (key_we) begin
      exp_mem[key_waddr] <= key_wexp;
      if (key_wident) begin
        id_mem[key_waddr] <= key_wid;
      end
    end
    key_rexp <= exp_mem[key_raddr];
    key_rid <= id_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      pos_rpresent <= 1'b0;
    end else begin
      if (pos_we) begin
        present_r[pos_waddr] <= pos_wpresent;
      end
      pos_rpresent <= present_r[pos_raddr];
    end
  end
endmodule
`default_nettype wire

### sv/lease_expiry_indexed_min_heap.sv
`default_nettype none
// Indexed min-heap of lease entries, keyed by expiry with worker id as tie-break.
// Input channel: an operation (insert, remove, reposition), a handle, an expiry
// and a worker id are transferred when start is high and busy is low.
// Result channel: out_valid is high for exactly one cycle with status, entry
// count and the current minimum entry; the receiver cannot stall it.
// A rejected operation goes straight from the entry state to reading the
// minimum; an accepted one may first sift its entry up or down the heap.
// Each synchronous memory has a single read port, so every level of a sift
// reads the node, its parent or children and their keys one after another
// before the swap is written back.
// One operation is handled at a time; busy is high from the cycle after the
// transfer until the result strobe rises, and a new transfer can be taken in
// the strobe cycle.
// At reset every handle is marked absent and the entry count is zero; no
// clearing pass is needed, so the block accepts work in the first cycle after
// reset is released.
module lease_expiry_indexed_min_heap
  import leimh_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic [HandleW-1:0] in_handle,
  input  wire logic [KeyW-1:0]    in_expiry_ms,
  input  wire logic [KeyW-1:0]    in_worker_ident,
  output logic                    out_valid,
  output logic                    out_status,
  output logic      [CountW-1:0]  out_entry_count,
  output logic                    out_min_valid,
  output logic      [HandleW-1:0] out_min_handle,
  output logic      [KeyW-1:0]    out_min_expiry_ms,
  output logic      [KeyW-1:0]    out_min_worker_ident
);
  localparam int unsigned DEPTH = (HEAP_DEPTH < HandleCount) ? HEAP_DEPTH : HandleCount;
  localparam int unsigned PW = $clog2(DEPTH) + 1;
  localparam logic [PW-1:0] Full = PW'(DEPTH);

  state_t state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [HandleW-1:0] h_r, h_nxt;
  logic [KeyW-1:0]    exp_r, exp_nxt;
  logic [KeyW-1:0]    id_r, id_nxt;
  logic [PW-1:0]      len_r, len_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      kid_r, kid_nxt;
  logic               up_r, up_nxt;
  logic               first_r, first_nxt;
  logic               rej_r, rej_nxt;
  logic [HandleW-1:0] sh_r, sh_nxt;
  logic [KeyW-1:0]    se_r, se_nxt, si_r, si_nxt;
  logic [HandleW-1:0] oh_r, oh_nxt;
  logic [KeyW-1:0]    oe_r, oe_nxt, oi_r, oi_nxt;
  logic [HandleW-1:0] bh_r, bh_nxt;

  logic               slot_we, pos_we, pos_wpresent, key_we, key_wident;
  logic [PW-2:0]      slot_waddr, slot_raddr, pos_wdata, pos_rdata;
  logic [HandleW-1:0] slot_wdata, slot_rdata, pos_waddr, pos_raddr;
  logic [HandleW-1:0] key_waddr, key_raddr;
  logic               pos_rpresent;
  logic [KeyW-1:0]    key_wexp, key_wid, key_rexp, key_rid;
  logic               ov_nxt;
  logic [PW-1:0]      par;
  logic [PW-1:0]      kid_inc;

  leimh_store #(.DEPTH(DEPTH), .PW(PW)) u_store (
    .clk, .rst_n, .slot_we, .slot_waddr, .slot_wdata, .slot_raddr, .slot_rdata,
    .pos_we, .pos_wpresent, .pos_waddr, .pos_wdata, .pos_raddr, .pos_rpresent,
    .pos_rdata, .key_we, .key_waddr, .key_wident, .key_wexp, .key_wid, .key_raddr,
    .key_rexp, .key_rid
  );

  assign par = (pos_r - PW'(1)) >> 1;
  assign kid_inc = kid_r + PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; h_r <= h_nxt; exp_r <= exp_nxt; id_r <= id_nxt;
    pos_r <= pos_nxt; kid_r <= kid_nxt; up_r <= up_nxt; first_r <= first_nxt;
    rej_r <= rej_nxt; sh_r <= sh_nxt; se_r <= se_nxt; si_r <= si_nxt;
    oh_r <= oh_nxt; oe_r <= oe_nxt; oi_r <= oi_nxt;
    bh_r <= bh_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; h_nxt = h_r; exp_nxt = exp_r; id_nxt = id_r;
    len_nxt = len_r; pos_nxt = pos_r; kid_nxt = kid_r; up_nxt = up_r;
    first_nxt = first_r; rej_nxt = rej_r;
    sh_nxt = sh_r; se_nxt = se_r; si_nxt = si_r;
    oh_nxt = oh_r; oe_nxt = oe_r; oi_nxt = oi_r;
    bh_nxt = bh_r;
    slot_we = 1'b0; slot_waddr = '0; slot_wdata = '0; slot_raddr = '0;
    pos_we = 1'b0; pos_wpresent = 1'b0; pos_waddr = '0; pos_wdata = '0; pos_raddr = h_r;
    key_we = 1'b0; key_waddr = h_r; key_wident = 1'b0; key_wexp = exp_r; key_wid = id_r;
    key_raddr = '0;
    ov_nxt = 1'b0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt = in_operation; h_nxt = in_handle;
          exp_nxt = in_expiry_ms; id_nxt = in_worker_ident;
          pos_raddr = in_handle;
          state_nxt = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        rej_nxt = 1'b1;
        first_nxt = 1'b1;
        up_nxt = 1'b0;
        state_nxt = ST_RD_MIN;
        case (op_r)
          OP_INSERT: begin
            if (!pos_rpresent && len_r < Full) begin
              rej_nxt = 1'b0;
              key_we = 1'b1; key_wident = 1'b1;
              slot_we = 1'b1; slot_waddr = len_r[PW-2:0]; slot_wdata = h_r;
              pos_we = 1'b1; pos_wpresent = 1'b1; pos_waddr = h_r;
              pos_wdata = len_r[PW-2:0];
              pos_nxt = len_r; len_nxt = len_r + PW'(1);
              up_nxt = 1'b1;
              state_nxt = ST_RD_SELF;
            end
          end
          OP_REMOVE: begin
            if (pos_rpresent) begin
              rej_nxt = 1'b0;
              pos_we = 1'b1; pos_wpresent = 1'b0; pos_waddr = h_r;
              pos_wdata = pos_rdata;
              pos_nxt = {1'b0, pos_rdata};
              len_nxt = len_r - PW'(1);
              slot_raddr = len_nxt[PW-2:0];
              if ({1'b0, pos_rdata} != len_nxt) begin
                state_nxt = ST_PLACE;
              end
            end
          end
          OP_REPOSITION: begin
            if (pos_rpresent) begin
              rej_nxt = 1'b0;
              key_we = 1'b1;
              pos_nxt = {1'b0, pos_rdata};
              state_nxt = ST_RD_SELF;
            end
          end
          default: begin
            rej_nxt = 1'b1;
          end
        endcase
      end
      ST_PLACE: begin
        slot_we = 1'b1; slot_waddr = pos_r[PW-2:0]; slot_wdata = slot_rdata;
        pos_we = 1'b1; pos_wpresent = 1'b1; pos_waddr = slot_rdata;
        pos_wdata = pos_r[PW-2:0];
        state_nxt = ST_RD_SELF;
      end
      ST_RD_SELF: begin
        slot_raddr = pos_r[PW-2:0];
        state_nxt = ST_WAIT_SELF;
      end
      ST_WAIT_SELF: begin
        key_raddr = slot_rdata; sh_nxt = slot_rdata;
        state_nxt = ST_RD_PARENT;
      end
      ST_RD_PARENT: begin
        se_nxt = key_rexp; si_nxt = key_rid;
        slot_raddr = par[PW-2:0];
        if (pos_r == '0 || (!up_r && !first_r)) begin
          up_nxt = 1'b0;
          state_nxt = ST_RD_KIDA;
        end else begin
          state_nxt = ST_WAIT_PARENT;
        end
      end
      ST_WAIT_PARENT: begin
        key_raddr = slot_rdata; oh_nxt = slot_rdata;
        kid_nxt = par;
        state_nxt = ST_DECIDE;
      end
      ST_RD_KIDA: begin
        kid_nxt = {pos_r[PW-2:0], 1'b1};
        slot_raddr = kid_nxt[PW-2:0];
        if (pos_r >= (len_r >> 1)) begin
          state_nxt = ST_RD_MIN;
        end else begin
          state_nxt = ST_WAIT_KIDA;
        end
      end
      ST_WAIT_KIDA: begin
        key_raddr = slot_rdata; oh_nxt = slot_rdata;
        state_nxt = ST_RD_KIDB;
      end
      ST_RD_KIDB: begin
        oe_nxt = key_rexp; oi_nxt = key_rid;
        slot_raddr = kid_inc[PW-2:0];
        if (kid_inc < len_r) begin
          state_nxt = ST_WAIT_KIDB;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_WAIT_KIDB: begin
        key_raddr = slot_rdata; bh_nxt = slot_rdata;
        state_nxt = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        if (earlier(key_rexp, key_rid, oe_r, oi_r)) begin
          oh_nxt = bh_r; oe_nxt = key_rexp; oi_nxt = key_rid;
          kid_nxt = kid_inc;
        end
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_RD_MIN;
        if (up_r || (first_r && pos_r != '0)) begin
          if (earlier(se_r, si_r, key_rexp, key_rid) && kid_r == par) begin
            slot_we = 1'b1; slot_waddr = pos_r[PW-2:0]; slot_wdata = oh_r;
            pos_we = 1'b1; pos_wpresent = 1'b1; pos_waddr = oh_r;
            pos_wdata = pos_r[PW-2:0];
            up_nxt = 1'b1; first_nxt = 1'b0;
            pos_nxt = par;
            state_nxt = ST_SWAP_B;
          end else if (first_r && !up_r) begin
            first_nxt = 1'b0;
            state_nxt = ST_RD_KIDA;
          end
        end else if (earlier(oe_r, oi_r, se_r, si_r)) begin
          slot_we = 1'b1; slot_waddr = pos_r[PW-2:0]; slot_wdata = oh_r;
          pos_we = 1'b1; pos_wpresent = 1'b1; pos_waddr = oh_r;
          pos_wdata = pos_r[PW-2:0];
          first_nxt = 1'b0;
          pos_nxt = kid_r;
          state_nxt = ST_SWAP_B;
        end
        if (state_nxt == ST_SWAP_B) begin
          // The moving entry is written at its new position in the next cycle.
          bh_nxt = sh_r;
          state_nxt = ST_PLACE;
        end
      end
      ST_RD_MIN: begin
        slot_raddr = '0;
        state_nxt = ST_WAIT_MIN;
      end
      ST_WAIT_MIN: begin
        key_raddr = slot_rdata; oh_nxt = slot_rdata;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (state_r == ST_PLACE && first_r == 1'b0) begin
      slot_wdata = bh_r;
      pos_waddr = bh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT) begin
      out_status <= rej_r;
      out_entry_count <= CountW'(len_r);
      out_min_valid <= (len_r != '0);
      out_min_handle <= (len_r != '0) ? oh_r : '0;
      out_min_expiry_ms <= (len_r != '0) ? key_rexp : '0;
      out_min_worker_ident <= (len_r != '0) ? key_rid : '0;
    end
  end
endmodule
`default_nettype wire

### sv/leimh_checker.sv
`default_nettype none
`include "lease_expiry_indexed_min_heap_macros.svh"
module leimh_checker
  import leimh_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic              out_min_valid,
  input wire logic [CountW-1:0] out_entry_count
);
  `LEIMH_ASSERT_IMP(a_minv, out_valid, out_min_valid == (out_entry_count != '0))
  `LEIMH_ASSERT_NEXT(a_busy, start && !busy, busy)
  `LEIMH_ASSERT_NEXT(a_one, out_valid, !out_valid)
  `LEIMH_ASSERT_IMP(a_cnt, out_valid, out_entry_count <= CountW'(HandleCount))
endmodule
bind lease_expiry_indexed_min_heap leimh_checker u_leimh_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_min_valid, .out_entry_count
);
`default_nettype wire
